### sv/uv_sphere_vertex_generator_defines.svh
// Assertion macros for the checker of the UV-sphere vertex generator
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH

// Concurrent check on clk, held off while reset is asserted
`define UVS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on clk that also holds during reset
`define UVS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/uvs_pkg.sv
// Types, constants and helper functions of the UV-sphere vertex generator
package uvs_pkg;

  localparam int IDX_W      = 12;
  localparam int POS_W      = 17;
  localparam int TEX_W      = 17;
  localparam int REM_W      = 7;   // grid side is a 7 bit register, so n-1 fits in 7 bits
  localparam int ANG_W      = 32;
  localparam int CW         = 34;  // CORDIC datapath width
  localparam int UNIT_W     = 32;  // Q1.30 sine/cosine after the CORDIC
  localparam int PROD_W     = 49;  // size (17 bit signed) times unit
  localparam int DIV_STEPS  = 32;
  localparam int TEX_STEP   = 16;
  localparam int THETA_STEP = 31;
  localparam int MAX_ATAN   = 24;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [PROD_W-1:0] HALF_Q30_P = 49'sd536870912;
  localparam logic signed [63:0] HALF_Q30_W = 64'sd536870912;
  localparam logic signed [18:0] POS_MAX = 19'sd65535;
  localparam logic signed [18:0] POS_MIN = -19'sd65535;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2,
    REG_GRID   = 2'd3
  } cfg_reg_t;

  // Fields that ride along the whole pipe
  typedef struct packed {
    logic             pv;
    logic             qv;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] below;
    logic [IDX_W-1:0] right;
    logic [IDX_W-1:0] diag;
    logic [TEX_W-1:0] tu;
    logic [TEX_W-1:0] tv;
  } side_t;

  // Long-division cell contents: row and column each divided by m
  typedef struct packed {
    side_t            side;
    logic [REM_W-1:0] m;
    logic [REM_W-1:0] rr;
    logic [REM_W-1:0] cr;
    logic [32:0]      rq;
    logic [32:0]      cq;
    logic [ANG_W-1:0] theta;
    logic [ANG_W-1:0] phi;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } rot_t;

  // CORDIC cell contents: both angles rotate side by side
  typedef struct packed {
    side_t      side;
    logic [1:0] tq;
    logic [1:0] pq;
    rot_t       th;
    rot_t       ph;
  } cor_t;

  // Arctangent of 2^-i in 2^-32 turns
  function automatic logic [ANG_W-1:0] atan_turn(input int unsigned i);
    logic [ANG_W-1:0] a;
    case (i)
      0:  a = 32'h20000000;  1:  a = 32'h12E4051E;  2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;  4:  a = 32'h028B0D43;  5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;  7:  a = 32'h00517C55;  8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;  10: a = 32'h000A2F98;  11: a = 32'h000517CC;
      12: a = 32'h00028BE6;  13: a = 32'h000145F3;  14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;  16: a = 32'h000028BE;  17: a = 32'h0000145F;
      18: a = 32'h00000A30;  19: a = 32'h00000518;  20: a = 32'h0000028C;
      21: a = 32'h00000146;  22: a = 32'h000000A3;  23: a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Round-to-nearest correction: remainder plus half the divisor reaches the divisor
  function automatic logic rnd_up(input logic [REM_W-1:0] r, input logic [REM_W-1:0] m);
    return ({1'b0, r} + {2'b0, m[REM_W-1:1]}) >= {1'b0, m};
  endfunction

  // Round a Q1.30 by Q8.8 product to Q8.8 and clamp to +-65535
  function automatic logic [POS_W-1:0] sat_pos(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [18:0]       v;
    s = p + HALF_Q30_P;
    v = s[48:30];
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return v[POS_W-1:0];
  endfunction

endpackage

### sv/uvs_div_cell.sv
// One restoring long-division cell: one quotient bit each for row/m and col/m
module uvs_div_cell
  import uvs_pkg::*;
#(
  parameter int STEP = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  div_t in_d,
  output logic out_vld,
  output div_t out_d
);

  logic             vld_r;
  div_t             d_r, d_nxt;
  logic [REM_W:0]   rt, ct;
  logic             rge, cge;

  // shift in a zero bit, subtract m when it fits
  always_comb begin
    d_nxt = in_d;
    rt    = {in_d.rr, 1'b0};
    ct    = {in_d.cr, 1'b0};
    rge   = rt >= {1'b0, in_d.m};
    cge   = ct >= {1'b0, in_d.m};
    d_nxt.rr = rge ? REM_W'(rt - {1'b0, in_d.m}) : rt[REM_W-1:0];
    d_nxt.cr = cge ? REM_W'(ct - {1'b0, in_d.m}) : ct[REM_W-1:0];
    d_nxt.rq = {in_d.rq[31:0], rge};
    d_nxt.cq = {in_d.cq[31:0], cge};
    // texture coordinates: sixteen fraction bits done
    if (STEP == TEX_STEP) begin
      d_nxt.side.tu = in_d.side.pv ?
        TEX_W'(d_nxt.cq[TEX_W-1:0] + TEX_W'(rnd_up(d_nxt.cr, in_d.m))) : '0;
      d_nxt.side.tv = in_d.side.pv ?
        TEX_W'(d_nxt.rq[TEX_W-1:0] + TEX_W'(rnd_up(d_nxt.rr, in_d.m))) : '0;
    end
    // latitude angle is a half turn scale
    if (STEP == THETA_STEP) begin
      d_nxt.theta = d_nxt.rq[ANG_W-1:0] + ANG_W'(rnd_up(d_nxt.rr, in_d.m));
    end
    // longitude angle is a full turn scale, wrapping
    if (STEP == DIV_STEPS) begin
      d_nxt.phi = d_nxt.cq[ANG_W-1:0] + ANG_W'(rnd_up(d_nxt.cr, in_d.m));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

### sv/uvs_cordic_cell.sv
// One CORDIC rotation cell, working on the latitude and longitude angles together
module uvs_cordic_cell
  import uvs_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  cor_t in_d,
  output logic out_vld,
  output cor_t out_d
);

  localparam logic signed [CW-1:0] ATAN = $signed({2'b00, atan_turn(STAGE)});

  logic vld_r;
  cor_t d_r, d_nxt;

  function automatic rot_t rot(input rot_t a);
    rot_t b;
    logic signed [CW-1:0] dx, dy;
    dx = $signed(a.y) >>> STAGE;
    dy = $signed(a.x) >>> STAGE;
    if (!a.z[CW-1]) begin
      b.x = $signed(a.x) - dx;
      b.y = $signed(a.y) + dy;
      b.z = $signed(a.z) - ATAN;
    end else begin
      b.x = $signed(a.x) + dx;
      b.y = $signed(a.y) - dy;
      b.z = $signed(a.z) + ATAN;
    end
    return b;
  endfunction

  // rotate towards zero residual angle
  always_comb begin
    d_nxt    = in_d;
    d_nxt.th = rot(in_d.th);
    d_nxt.ph = rot(in_d.ph);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

### sv/uv_sphere_vertex_generator.sv
// UV-sphere vertex generator: grid point in, vertex position, texture and quad indices out
//
// Input channel in_valid/in_ready carries one grid point (in_row, in_col) per transfer.
// Output channel out_valid/out_ready carries one vertex result per accepted point, in order.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 size_x, 1 size_y,
// 2 size_z, 3 grid_points) in the same cycle; write only while the pipe is empty.
// Throughput: one point per cycle while the output is not held. The point passes one
// input stage, 32 long-division cells (one quotient bit each), ANGLE_STAGES CORDIC
// cells, a quadrant stage, three multiply-and-round stages and the output register;
// the input stage loads at the transfer edge itself.
// Reset: registers return to size 1.0 and n = 30; the pipe is emptied.
// Stall: while out_valid is high and out_ready low the whole pipe holds and in_ready
// drops; otherwise a point is taken every cycle, also while a result is being taken.
// Points outside the grid come out with point_valid low and all other fields zero.
module uv_sphere_vertex_generator
  import uvs_pkg::*;
#(
  parameter int MAX_GRID     = 64,
  parameter int ANGLE_STAGES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [5:0]              in_row,
  input  logic [5:0]              in_col,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_point_valid,
  output logic [IDX_W-1:0]        out_vertex_index,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [POS_W-1:0] out_pos_z,
  output logic [TEX_W-1:0]        out_tex_u,
  output logic [TEX_W-1:0]        out_tex_v,
  output logic                    out_quad_valid,
  output logic [IDX_W-1:0]        out_below_index,
  output logic [IDX_W-1:0]        out_right_index,
  output logic [IDX_W-1:0]        out_diagonal_index
);

  // configuration registers
  logic [15:0]      size_x_r, size_y_r, size_z_r;
  logic [6:0]       grid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 16'd256;
      size_y_r <= 16'd256;
      size_z_r <= 16'd256;
      grid_r   <= 7'd30;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SIZE_X: size_x_r <= cfg_wdata;
        REG_SIZE_Y: size_y_r <= cfg_wdata;
        REG_SIZE_Z: size_z_r <= cfg_wdata;
        REG_GRID:   grid_r   <= cfg_wdata[6:0];
        default:    ;
      endcase
    end
  end

  // whole pipe moves unless the output is held
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // input stage: grid size, flags, indices and the integer quotient bit
  logic [6:0]       n_c, m_c, row_e, col_e;
  logic [12:0]      idx_c;
  div_t             d0_nxt, d0_r;
  logic             v0_r;

  always_comb begin
    n_c = grid_r;
    if (grid_r < 7'd2) n_c = 7'd2;
    if (32'(grid_r) > MAX_GRID) n_c = 7'(MAX_GRID);
    m_c   = n_c - 7'd1;
    row_e = {1'b0, in_row};
    col_e = {1'b0, in_col};
    idx_c = 13'(13'(row_e) * 13'(n_c)) + 13'(col_e);
    d0_nxt = '0;
    d0_nxt.m       = m_c;
    d0_nxt.side.pv = (row_e < n_c) && (col_e < n_c);
    d0_nxt.side.qv = (row_e < m_c) && (col_e < m_c);
    if (d0_nxt.side.pv) begin
      d0_nxt.side.idx = idx_c[IDX_W-1:0];
    end
    if (d0_nxt.side.qv) begin
      d0_nxt.side.below = IDX_W'(idx_c + 13'(n_c));
      d0_nxt.side.right = IDX_W'(idx_c + 13'd1);
      d0_nxt.side.diag  = IDX_W'(idx_c + 13'(n_c) + 13'd1);
    end
    d0_nxt.rq[0] = row_e >= m_c;
    d0_nxt.cq[0] = col_e >= m_c;
    d0_nxt.rr    = d0_nxt.rq[0] ? 7'(row_e - m_c) : row_e;
    d0_nxt.cr    = d0_nxt.cq[0] ? 7'(col_e - m_c) : col_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_r <= d0_nxt;
    end
  end

  // long-division chain
  div_t dv   [0:DIV_STEPS];
  logic dv_v [0:DIV_STEPS];
  assign dv[0]   = d0_r;
  assign dv_v[0] = v0_r;

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    uvs_div_cell #(.STEP(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .in_vld  (dv_v[k-1]),
      .in_d    (dv[k-1]),
      .out_vld (dv_v[k]),
      .out_d   (dv[k])
    );
  end

  // CORDIC chain, started from the gain-corrected unit vector
  cor_t cr   [0:ANGLE_STAGES];
  logic cr_v [0:ANGLE_STAGES];

  always_comb begin
    cr[0].side = dv[DIV_STEPS].side;
    cr[0].tq   = dv[DIV_STEPS].theta[31:30];
    cr[0].pq   = dv[DIV_STEPS].phi[31:30];
    cr[0].th.x = CORDIC_GAIN;
    cr[0].th.y = '0;
    cr[0].th.z = $signed({4'b0000, dv[DIV_STEPS].theta[29:0]});
    cr[0].ph.x = CORDIC_GAIN;
    cr[0].ph.y = '0;
    cr[0].ph.z = $signed({4'b0000, dv[DIV_STEPS].phi[29:0]});
  end
  assign cr_v[0] = dv_v[DIV_STEPS];

  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cor
    uvs_cordic_cell #(.STAGE(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .in_vld  (cr_v[k]),
      .in_d    (cr[k]),
      .out_vld (cr_v[k+1]),
      .out_d   (cr[k+1])
    );
  end

  // quadrant fold
  side_t                    sq_side_r;
  logic                     sq_v_r;
  logic signed [UNIT_W-1:0] sth_r, cth_r, sph_r, cph_r;
  logic signed [UNIT_W-1:0] sth_nxt, cth_nxt, sph_nxt, cph_nxt;

  function automatic logic signed [UNIT_W-1:0] neg(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = -v;
    return $signed(t[UNIT_W-1:0]);
  endfunction

  function automatic logic signed [UNIT_W-1:0] pos(input logic signed [CW-1:0] v);
    return $signed(v[UNIT_W-1:0]);
  endfunction

  always_comb begin
    case (cr[ANGLE_STAGES].tq)
      2'd0: begin
        cth_nxt = pos(cr[ANGLE_STAGES].th.x);
        sth_nxt = pos(cr[ANGLE_STAGES].th.y);
      end
      2'd1: begin
        cth_nxt = neg(cr[ANGLE_STAGES].th.y);
        sth_nxt = pos(cr[ANGLE_STAGES].th.x);
      end
      2'd2: begin
        cth_nxt = neg(cr[ANGLE_STAGES].th.x);
        sth_nxt = neg(cr[ANGLE_STAGES].th.y);
      end
      default: begin
        cth_nxt = pos(cr[ANGLE_STAGES].th.y);
        sth_nxt = neg(cr[ANGLE_STAGES].th.x);
      end
    endcase
    case (cr[ANGLE_STAGES].pq)
      2'd0: begin
        cph_nxt = pos(cr[ANGLE_STAGES].ph.x);
        sph_nxt = pos(cr[ANGLE_STAGES].ph.y);
      end
      2'd1: begin
        cph_nxt = neg(cr[ANGLE_STAGES].ph.y);
        sph_nxt = pos(cr[ANGLE_STAGES].ph.x);
      end
      2'd2: begin
        cph_nxt = neg(cr[ANGLE_STAGES].ph.x);
        sph_nxt = neg(cr[ANGLE_STAGES].ph.y);
      end
      default: begin
        cph_nxt = pos(cr[ANGLE_STAGES].ph.y);
        sph_nxt = neg(cr[ANGLE_STAGES].ph.x);
      end
    endcase
  end

  // angle products
  side_t                    m1_side_r;
  logic                     m1_v_r;
  logic signed [63:0]       pxc_r, pzs_r;
  logic signed [UNIT_W-1:0] m1_cth_r;

  // rounded unit vectors
  side_t                    m2_side_r;
  logic                     m2_v_r;
  logic signed [UNIT_W-1:0] ux_r, uy_r, uz_r;
  logic signed [63:0]       rx_sum, rz_sum;

  assign rx_sum = pxc_r + HALF_Q30_W;
  assign rz_sum = pzs_r + HALF_Q30_W;

  // scaled by the radii
  side_t                    m3_side_r;
  logic                     m3_v_r;
  logic signed [PROD_W-1:0] qx_r, qy_r, qz_r;

  // output register
  side_t                    o_side_r;
  logic                     o_v_r;
  logic [POS_W-1:0]         ox_r, oy_r, oz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (adv) begin
      sq_v_r <= cr_v[ANGLE_STAGES];
      m1_v_r <= sq_v_r;
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
      o_v_r  <= m3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side_r <= cr[ANGLE_STAGES].side;
      sth_r     <= sth_nxt;
      cth_r     <= cth_nxt;
      sph_r     <= sph_nxt;
      cph_r     <= cph_nxt;
      m1_side_r <= sq_side_r;
      pxc_r     <= sth_r * cph_r;
      pzs_r     <= sth_r * sph_r;
      m1_cth_r  <= cth_r;
      m2_side_r <= m1_side_r;
      ux_r      <= $signed(rx_sum[61:30]);
      uz_r      <= $signed(rz_sum[61:30]);
      uy_r      <= m1_cth_r;
      m3_side_r <= m2_side_r;
      qx_r      <= $signed({1'b0, size_x_r}) * ux_r;
      qy_r      <= $signed({1'b0, size_y_r}) * uy_r;
      qz_r      <= $signed({1'b0, size_z_r}) * uz_r;
      o_side_r  <= m3_side_r;
      ox_r      <= m3_side_r.pv ? sat_pos(qx_r) : '0;
      oy_r      <= m3_side_r.pv ? sat_pos(qy_r) : '0;
      oz_r      <= m3_side_r.pv ? sat_pos(qz_r) : '0;
    end
  end

  assign out_valid          = o_v_r;
  assign out_point_valid    = o_side_r.pv;
  assign out_vertex_index   = o_side_r.idx;
  assign out_pos_x          = $signed(ox_r);
  assign out_pos_y          = $signed(oy_r);
  assign out_pos_z          = $signed(oz_r);
  assign out_tex_u          = o_side_r.tu;
  assign out_tex_v          = o_side_r.tv;
  assign out_quad_valid     = o_side_r.qv;
  assign out_below_index    = o_side_r.below;
  assign out_right_index    = o_side_r.right;
  assign out_diagonal_index = o_side_r.diag;

endmodule

### sv/uvs_checker.sv
// Port-level checks of the UV-sphere vertex generator, bound to the top level
`include "uv_sphere_vertex_generator_defines.svh"

module uvs_checker
  import uvs_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_point_valid,
  input logic [IDX_W-1:0]        out_vertex_index,
  input logic signed [POS_W-1:0] out_pos_x,
  input logic signed [POS_W-1:0] out_pos_y,
  input logic signed [POS_W-1:0] out_pos_z,
  input logic [TEX_W-1:0]        out_tex_u,
  input logic [TEX_W-1:0]        out_tex_v,
  input logic                    out_quad_valid,
  input logic [IDX_W-1:0]        out_below_index,
  input logic [IDX_W-1:0]        out_right_index,
  input logic [IDX_W-1:0]        out_diagonal_index
);

  logic held, off_grid_zero, no_quad_zero, corners_ok;

  assign held          = out_valid && !out_ready;
  assign off_grid_zero = out_vertex_index == '0 && out_pos_x == '0 && out_pos_y == '0 &&
                         out_pos_z == '0 && out_tex_u == '0 && out_tex_v == '0 &&
                         !out_quad_valid;
  assign no_quad_zero  = out_below_index == '0 && out_right_index == '0 &&
                         out_diagonal_index == '0;
  assign corners_ok    = out_point_valid &&
                         out_right_index == 12'(out_vertex_index + 12'd1) &&
                         out_diagonal_index == 12'(out_below_index + 12'd1);

  // a held result stays put
  `UVS_ASSERT(a_out_hold, held |=> out_valid && $stable(out_vertex_index), "result dropped")

  // off-grid points carry nothing
  `UVS_ASSERT(a_off_grid_zero, out_valid && !out_point_valid |-> off_grid_zero, "off-grid")

  // no quad, no triangle corners
  `UVS_ASSERT(a_no_quad_zero, out_valid && !out_quad_valid |-> no_quad_zero, "stray corners")

  // quad corners hang together
  `UVS_ASSERT(a_quad_corners, out_valid && out_quad_valid |-> corners_ok, "bad quad corners")

  // the pipe is empty straight after reset
  `UVS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result right after reset")

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (.*);

### bench/tb_uv_sphere_vertex_generator.sv
// Self-checking bench for the UV-sphere vertex generator: scoreboard, drivers and monitors
`timescale 1ns / 1ps

module tb_uv_sphere_vertex_generator;
  import uvs_pkg::*;

  localparam int GRID_LIMIT = 64;
  localparam int ROT_STAGES = 16;

  typedef struct {
    logic             point_valid;
    logic [11:0]      vertex_index;
    logic [16:0]      pos_x;
    logic [16:0]      pos_y;
    logic [16:0]      pos_z;
    logic [16:0]      tex_u;
    logic [16:0]      tex_v;
    logic             quad_valid;
    logic [11:0]      below_index;
    logic [11:0]      right_index;
    logic [11:0]      diagonal_index;
  } vertex_t;

  // Predicts vertex results and compares them in order
  class vertex_scoreboard;
    vertex_t     pending_vertices[$];
    longint      radius_x, radius_y, radius_z;
    int unsigned side_reg;
    int          errors;

    function new();
      radius_x = 256; radius_y = 256; radius_z = 256;
      side_reg = 30;
      errors   = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        REG_SIZE_X: radius_x = val;
        REG_SIZE_Y: radius_y = val;
        REG_SIZE_Z: radius_z = val;
        REG_GRID:   side_reg = val[6:0];
        default:    ;
      endcase
    endfunction

    function longint round30(longint p);
      return (p + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Rotation-mode CORDIC on a 2^-32 turn angle, Q1.30 results
    function void rotate(logic [31:0] ang, output longint s, output longint c);
      longint x, y, z, dx, dy, a;
      x = 652032874; y = 0;
      z = longint'(ang[29:0]);
      for (int i = 0; i < ROT_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        a  = longint'(atan_turn(i));
        if (z >= 0) begin
          x -= dx; y += dy; z -= a;
        end else begin
          x += dx; y -= dy; z += a;
        end
      end
      case (ang[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function logic [16:0] scale(longint sz, longint unit);
      longint v;
      v = round30(sz * unit);
      if (v > 65535) v = 65535;
      if (v < -65535) v = -65535;
      return v[16:0];
    endfunction

    // Note an accepted grid point and queue its expected vertex
    function void note_point(logic [5:0] row, logic [5:0] col);
      vertex_t    e;
      longint     n, m, idx, st, ct, sp, cp;
      logic [63:0] wide;
      logic [31:0] theta, phi;
      e = '{default: 0};
      n = side_reg;
      if (n < 2) n = 2;
      if (n > GRID_LIMIT) n = GRID_LIMIT;
      m = n - 1;
      if (row < n && col < n) begin
        idx = row * n + col;
        e.point_valid  = 1;
        e.vertex_index = idx[11:0];
        wide  = ((longint'(row) << 31) + m / 2) / m;
        theta = wide[31:0];
        wide  = ((longint'(col) << 32) + m / 2) / m;
        phi   = wide[31:0];
        rotate(theta, st, ct);
        rotate(phi, sp, cp);
        e.pos_x = scale(radius_x, round30(st * cp));
        e.pos_y = scale(radius_y, ct);
        e.pos_z = scale(radius_z, round30(st * sp));
        wide = ((longint'(col) << 16) + m / 2) / m;
        e.tex_u = wide[16:0];
        wide = ((longint'(row) << 16) + m / 2) / m;
        e.tex_v = wide[16:0];
        if (row < m && col < m) begin
          e.quad_valid = 1;
          wide = idx + n;     e.below_index    = wide[11:0];
          wide = idx + 1;     e.right_index    = wide[11:0];
          wide = idx + n + 1; e.diagonal_index = wide[11:0];
        end
      end
      pending_vertices.push_back(e);
    endfunction

    task report(string what, logic [16:0] got, logic [16:0] want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
      errors++;
    endtask

    // Compare one result transfer against the oldest expectation
    task check_vertex(vertex_t a);
      vertex_t e;
      if (pending_vertices.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      e = pending_vertices.pop_front();
      if (a.point_valid !== e.point_valid) report("point_valid", a.point_valid, e.point_valid);
      if (a.vertex_index !== e.vertex_index)
        report("vertex_index", a.vertex_index, e.vertex_index);
      if (a.pos_x !== e.pos_x) report("pos_x", a.pos_x, e.pos_x);
      if (a.pos_y !== e.pos_y) report("pos_y", a.pos_y, e.pos_y);
      if (a.pos_z !== e.pos_z) report("pos_z", a.pos_z, e.pos_z);
      if (a.tex_u !== e.tex_u) report("tex_u", a.tex_u, e.tex_u);
      if (a.tex_v !== e.tex_v) report("tex_v", a.tex_v, e.tex_v);
      if (a.quad_valid !== e.quad_valid) report("quad_valid", a.quad_valid, e.quad_valid);
      if (a.below_index !== e.below_index) report("below_index", a.below_index, e.below_index);
      if (a.right_index !== e.right_index) report("right_index", a.right_index, e.right_index);
      if (a.diagonal_index !== e.diagonal_index)
        report("diagonal_index", a.diagonal_index, e.diagonal_index);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_wdata = 0;
  logic in_valid = 0, out_ready = 0;
  logic [5:0] in_row = 0, in_col = 0;
  logic in_ready, out_valid;
  logic out_point_valid, out_quad_valid;
  logic [11:0] out_vertex_index, out_below_index, out_right_index, out_diagonal_index;
  logic signed [16:0] out_pos_x, out_pos_y, out_pos_z;
  logic [16:0] out_tex_u, out_tex_v;

  int idle_send = 33, idle_recv = 79;
  vertex_scoreboard sb = new();

  uv_sphere_vertex_generator uut (.*);

  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) out_ready <= ($urandom_range(99) >= idle_recv);

  // Monitors for both channels
  always @(posedge clk) begin
    vertex_t a;
    if (rst_n && in_valid && in_ready) sb.note_point(in_row, in_col);
    if (rst_n && out_valid && out_ready) begin
      a.point_valid = out_point_valid;   a.vertex_index = out_vertex_index;
      a.pos_x = out_pos_x; a.pos_y = out_pos_y; a.pos_z = out_pos_z;
      a.tex_u = out_tex_u; a.tex_v = out_tex_v;
      a.quad_valid = out_quad_valid;     a.below_index = out_below_index;
      a.right_index = out_right_index;   a.diagonal_index = out_diagonal_index;
      sb.check_vertex(a);
    end
  end

  task automatic send_point(input logic [5:0] r, input logic [5:0] c);
    while ($urandom_range(99) < idle_send) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_row <= r; in_col <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_vertices.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_shape(input logic [15:0] sx, sy, sz, input logic [6:0] g);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_GRID, {9'd0, g});
  endtask

  // Random points: mostly inside the grid, some anywhere
  task automatic random_points(input int count);
    int n;
    n = (sb.side_reg < 2) ? 2 : (sb.side_reg > GRID_LIMIT ? GRID_LIMIT : sb.side_reg);
    repeat (count) begin
      if ($urandom_range(99) < 85)
        send_point(6'($urandom_range(n - 1)), 6'($urandom_range(n - 1)));
      else
        send_point(6'($urandom_range(63)), 6'($urandom_range(63)));
    end
  endtask

  initial begin
    #2_000_000;
    $display("** uv_sphere_vertex_generator: FAILED **");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset shape, corners, edges, outside the grid
    send_point(0, 0);   send_point(0, 29);  send_point(29, 0);  send_point(29, 29);
    send_point(28, 28); send_point(28, 29); send_point(29, 28); send_point(30, 0);
    send_point(0, 30);  send_point(63, 63); send_point(63, 0);  send_point(0, 63);
    send_point(15, 7);  send_point(14, 22); send_point(42, 21);
    drain();
    set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd64);
    send_point(0, 0); send_point(63, 63); send_point(62, 62); send_point(32, 16);
    send_point(21, 42);
    drain();
    set_shape(16'd0, 16'd0, 16'd0, 7'd0);
    send_point(0, 0); send_point(1, 1); send_point(0, 1); send_point(2, 0);

    // Random phases over several settings
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin idle_send = 79; idle_recv = 33; end
      if (ph == 6) begin idle_send = 0;  idle_recv = 0;  end
      drain();
      case (ph % 6)
        0: set_shape(16'd256, 16'd256, 16'd256, 7'd30);
        1: set_shape(16'hFFFF, 16'd0, 16'hFFFF, 7'd127);
        2: set_shape(16'd0, 16'hFFFF, 16'd12345, 7'd2);
        3: set_shape(16'($urandom), 16'($urandom), 16'($urandom), 7'd1);
        4: set_shape(16'($urandom), 16'($urandom), 16'($urandom), 7'd64);
        default: set_shape(16'($urandom), 16'($urandom), 16'($urandom),
                           7'($urandom_range(2, 64)));
      endcase
      random_points(75);
    end

    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending_vertices.size() == 0)
      $display("** uv_sphere_vertex_generator: PASSED **");
    else
      $display("** uv_sphere_vertex_generator: FAILED **");
    $finish;
  end

endmodule
